// ----- rtl/lrk_pkg.sv -----
// Shared types, constants and helper functions for the Lorenz RK4 integrator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lrk_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int ACC_BITS  = WORD_BITS + 4;               // exact k1+2k2+2k3+k4
  localparam int PROD_BITS = ACC_BITS + WORD_BITS + 1;    // product plus rounding
  localparam int QUO_BITS  = PROD_BITS - FRAC_BITS;
  localparam int STEP_BITS = WORD_BITS - 1;
  localparam int RCP_SHIFT = WORD_BITS + 3;

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [WORD_BITS-1:0] SIGMA_RST = 32'sd655360;
  localparam logic [WORD_BITS-1:0] BETA_RST  = 32'sd174763;
  localparam logic [WORD_BITS-1:0] RHO_RST   = 32'sd1835008;
  localparam logic [STEP_BITS-1:0] STEP_RST  = 31'd655;

  localparam logic [PROD_BITS-1:0] ADD_HALF  = PROD_BITS'(1) << FRAC_BITS;
  localparam logic [PROD_BITS-1:0] ADD_FULL  = PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_BITS-1:0] ADD_SIXTH = PROD_BITS'(6) << (FRAC_BITS - 1);

  // ceil(2^RCP_SHIFT / 3): exact floor division by three below 2^(WORD_BITS+1)
  localparam logic [RCP_SHIFT-1:0] RCP3 =
    RCP_SHIFT'(((65'd1 << RCP_SHIFT) + 65'd2) / 65'd3);

  localparam logic [3:0] UOP_LAST   = 4'd14;
  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef enum logic [1:0] {
    CFG_SIGMA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_RHO   = 2'd2,
    CFG_STEP  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef enum logic [4:0] {
    SRC_T0, SRC_T1, SRC_T2, SRC_S0, SRC_S1, SRC_S2,
    SRC_K0, SRC_K1, SRC_K2, SRC_A0, SRC_A1, SRC_A2,
    SRC_U, SRC_M, SRC_N, SRC_SIGMA, SRC_BETA, SRC_RHO, SRC_H
  } src_t;

  typedef enum logic [2:0] {
    UK_SUB, UK_ADD, UK_MUL, UK_ACC_SET, UK_ACC_ADD1, UK_ACC_ADD2
  } ukind_t;

  typedef enum logic [1:0] {
    RND_HALF, RND_FULL, RND_SIXTH
  } rnd_t;

  typedef struct packed {
    ukind_t kind;
    src_t   a;
    src_t   b;
    src_t   dst;
    rnd_t   rnd;
  } uop_t;

  typedef struct packed {
    logic load;
    logic begin_step;
    logic exec;
    logic time_adv;
    logic out_load;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
  } stat_t;

  // saturate a 33-bit sum to the word; top bit reports clipping
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [WORD_BITS:0] v);
    logic [WORD_BITS:0] r;
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r = {1'b1, (v[WORD_BITS] ? WMIN : WMAX)};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

  // micro-step table: one derivative evaluation, weighted sum, then stage update
  function automatic uop_t uop_at(input logic [1:0] phase, input logic [3:0] idx);
    uop_t u;
    rnd_t srnd;
    logic fin;
    fin  = (phase == PHASE_LAST);
    srnd = fin ? RND_SIXTH : ((phase == 2'd2) ? RND_FULL : RND_HALF);
    u = '{kind: UK_SUB, a: SRC_T1, b: SRC_T0, dst: SRC_U, rnd: RND_FULL};
    case (idx)
      4'd0:  u = '{UK_SUB, SRC_T1, SRC_T0, SRC_U, RND_FULL};
      4'd1:  u = '{UK_MUL, SRC_SIGMA, SRC_U, SRC_K0, RND_FULL};
      4'd2:  u = '{UK_SUB, SRC_RHO, SRC_T2, SRC_U, RND_FULL};
      4'd3:  u = '{UK_MUL, SRC_T0, SRC_U, SRC_M, RND_FULL};
      4'd4:  u = '{UK_SUB, SRC_M, SRC_T1, SRC_K1, RND_FULL};
      4'd5:  u = '{UK_MUL, SRC_T0, SRC_T1, SRC_M, RND_FULL};
      4'd6:  u = '{UK_MUL, SRC_BETA, SRC_T2, SRC_N, RND_FULL};
      4'd7:  u = '{UK_SUB, SRC_M, SRC_N, SRC_K2, RND_FULL};
      4'd8: begin
        u.kind = (phase == 2'd0) ? UK_ACC_SET : (fin ? UK_ACC_ADD1 : UK_ACC_ADD2);
      end
      4'd9:  u = '{UK_MUL, (fin ? SRC_A0 : SRC_K0), SRC_H, SRC_M, srnd};
      4'd10: u = '{UK_ADD, SRC_S0, SRC_M, (fin ? SRC_S0 : SRC_T0), RND_FULL};
      4'd11: u = '{UK_MUL, (fin ? SRC_A1 : SRC_K1), SRC_H, SRC_M, srnd};
      4'd12: u = '{UK_ADD, SRC_S1, SRC_M, (fin ? SRC_S1 : SRC_T1), RND_FULL};
      4'd13: u = '{UK_MUL, (fin ? SRC_A2 : SRC_K2), SRC_H, SRC_M, srnd};
      4'd14: u = '{UK_ADD, SRC_S2, SRC_M, (fin ? SRC_S2 : SRC_T2), RND_FULL};
      default: u = '{UK_SUB, SRC_T1, SRC_T0, SRC_U, RND_FULL};
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/lorenz_rk4_integrator.sv -----
// Top level of the Lorenz RK4 integrator: controller plus datapath.
// Uses lrk_pkg, lrk_ctrl and lrk_datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall): in_kind 0 loads in_load_x/y/z and
//   clears time; in_kind 1 advances one RK4 step of size step_size.
//   Output channel (out_valid / out_stall): one transaction per input with
//   the state, time and a saturation flag for that item.
//   Configuration: cfg_we with cfg_index 0..3 (sigma, beta, rho, step_size)
//   writes cfg_data; write only while the block is idle.
// Timing: a load is registered into the state, then into the output
//   register. A step runs 60 micro-steps on one shared multiplier, the
//   three final products with a divide by six. The next transaction is
//   accepted once the previous one is in the output register, even while
//   that result still waits.
// Reset: state and time clear, registers return to sigma 10, beta 8/3,
//   rho 28, step 655/65536; no output is pending.
// Stall: a waiting result holds in the output register; a finished item
//   holds in the controller until the register frees.
module lorenz_rk4_integrator import lrk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [WORD_BITS-1:0] in_load_x,
  input  logic [WORD_BITS-1:0] in_load_y,
  input  logic [WORD_BITS-1:0] in_load_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_x_out,
  output logic [WORD_BITS-1:0] out_y_out,
  output logic [WORD_BITS-1:0] out_z_out,
  output logic [WORD_BITS-1:0] out_time_out,
  output logic                 out_saturated
);

  cmd_t  cmd;
  stat_t stat;

  lrk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrk_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load_x    (in_load_x),
    .load_y    (in_load_y),
    .load_z    (in_load_z),
    .cmd       (cmd),
    .stat      (stat),
    .x_out     (out_x_out),
    .y_out     (out_y_out),
    .z_out     (out_z_out),
    .time_out  (out_time_out),
    .saturated (out_saturated)
  );

endmodule

// ----- rtl/lrk_mul.sv -----
// Shared multi-cycle scaled multiplier: |a|*|b| in two partial products,
// rounding, saturation and an optional reciprocal divide by six. Uses lrk_pkg.
`timescale 1ns / 1ps

module lrk_mul import lrk_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [ACC_BITS-1:0]  a,
  input  logic signed [WORD_BITS-1:0] b,
  input  rnd_t                        rnd,
  output logic                        done,
  output logic [WORD_BITS-1:0]        res,
  output logic                        clip
);

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_LO   = 7'b0000010,
    M_HI   = 7'b0000100,
    M_RND  = 7'b0001000,
    M_DLO  = 7'b0010000,
    M_DHI  = 7'b0100000,
    M_DOUT = 7'b1000000
  } mst_t;

  mst_t                 st_r, st_nxt;
  logic [ACC_BITS-1:0]  am_r;
  logic [WORD_BITS-1:0] bm_r;
  logic                 neg_r;
  rnd_t                 rnd_r;
  logic [PROD_BITS-1:0] p_r;
  logic [WORD_BITS:0]   num_r;
  logic [WORD_BITS-1:0] res_r;
  logic                 clip_r, done_r;

  logic [2*WORD_BITS-1:0]          lo_prod;
  logic [WORD_BITS+3:0]            hi_prod;
  logic [2*WORD_BITS-1:0]          dlo_prod;
  logic [WORD_BITS+3:0]            dhi_prod;
  logic [PROD_BITS-1:0]            rnd_add, shifted, dshift;
  logic [QUO_BITS-1:0]             q0, lim_q, six_q;
  logic [WORD_BITS-1:0]            lim;
  logic [WORD_BITS-1:0]            quo;

  assign lo_prod = am_r[WORD_BITS-1:0] * bm_r;
  assign hi_prod = am_r[ACC_BITS-1:WORD_BITS] * bm_r;

  // halved quotient times the reciprocal of three, in two partial products
  assign dlo_prod = num_r[WORD_BITS-1:0] * RCP3[WORD_BITS-1:0];
  assign dhi_prod = (WORD_BITS+4)'(num_r[WORD_BITS-1:0]) *
                    (WORD_BITS+4)'(RCP3[RCP_SHIFT-1:WORD_BITS]) +
                    (num_r[WORD_BITS] ? (WORD_BITS+4)'(RCP3) : (WORD_BITS+4)'(0));

  always_comb begin
    case (rnd_r)
      RND_HALF:  rnd_add = ADD_HALF;
      RND_SIXTH: rnd_add = ADD_SIXTH;
      default:   rnd_add = ADD_FULL;
    endcase
    shifted = (rnd_r == RND_HALF) ? (p_r >> (FRAC_BITS + 1)) : (p_r >> FRAC_BITS);
    q0      = shifted[QUO_BITS-1:0];
    lim     = neg_r ? WMIN : WMAX;
    lim_q   = QUO_BITS'(lim);
    six_q   = ((lim_q + 1'b1) << 2) + ((lim_q + 1'b1) << 1);
    dshift  = p_r >> RCP_SHIFT;
    quo     = dshift[WORD_BITS-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      M_IDLE: if (start) st_nxt = M_LO;
      M_LO:   st_nxt = M_HI;
      M_HI:   st_nxt = M_RND;
      M_RND:  st_nxt = (rnd_r == RND_SIXTH && q0 < six_q) ? M_DLO : M_IDLE;
      M_DLO:  st_nxt = M_DHI;
      M_DHI:  st_nxt = M_DOUT;
      M_DOUT: st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
      clip_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      clip_r <= 1'b0;
      unique case (st_r)
        M_RND: begin
          if (rnd_r == RND_SIXTH) begin
            if (q0 >= six_q) begin
              done_r <= 1'b1;
              clip_r <= 1'b1;
            end
          end else begin
            done_r <= 1'b1;
            clip_r <= (q0 > lim_q);
          end
        end
        M_DOUT: done_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      M_IDLE: begin
        if (start) begin
          am_r  <= a[ACC_BITS-1] ? ACC_BITS'(-a) : ACC_BITS'(a);
          bm_r  <= b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
          neg_r <= a[ACC_BITS-1] ^ b[WORD_BITS-1];
          rnd_r <= rnd;
        end
      end
      M_LO: p_r <= PROD_BITS'(lo_prod);
      M_HI: p_r <= p_r + (PROD_BITS'(hi_prod) << WORD_BITS) + rnd_add;
      M_RND: begin
        // saturated result first; the divide overwrites it when it runs
        if (q0 > lim_q) begin
          res_r <= neg_r ? WMIN : WMAX;
        end else begin
          res_r <= neg_r ? (WORD_BITS'(0) - q0[WORD_BITS-1:0]) : q0[WORD_BITS-1:0];
        end
        // divide by six as a halving then a divide by three
        num_r <= q0[WORD_BITS+1:1];
      end
      M_DLO: p_r <= PROD_BITS'(dlo_prod);
      M_DHI: p_r <= p_r + (PROD_BITS'(dhi_prod) << WORD_BITS);
      M_DOUT: res_r <= neg_r ? (WORD_BITS'(0) - quo) : quo;
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;
  assign clip = clip_r;

endmodule

// ----- rtl/lrk_datapath.sv -----
// Datapath: configuration, state, stage and derivative registers, the ALU
// and the shared multiplier. Driven by lrk_ctrl commands; uses lrk_pkg, lrk_mul.
`timescale 1ns / 1ps

module lrk_datapath import lrk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [WORD_BITS-1:0]  cfg_data,
  input  logic [WORD_BITS-1:0]  load_x,
  input  logic [WORD_BITS-1:0]  load_y,
  input  logic [WORD_BITS-1:0]  load_z,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [WORD_BITS-1:0]  x_out,
  output logic [WORD_BITS-1:0]  y_out,
  output logic [WORD_BITS-1:0]  z_out,
  output logic [WORD_BITS-1:0]  time_out,
  output logic                  saturated
);

  logic [WORD_BITS-1:0] sigma_r, beta_r, rho_r;
  logic [STEP_BITS-1:0] h_r;
  logic [WORD_BITS-1:0] s_r [3];
  logic [WORD_BITS-1:0] t_r [3];
  logic [WORD_BITS-1:0] k_r [3];
  logic [ACC_BITS-1:0]  acc_r [3];
  logic [WORD_BITS-1:0] u_r, m_r, n_r, time_r;
  logic                 clip_r;
  src_t                 mdst_r;
  logic [WORD_BITS-1:0] xo_r, yo_r, zo_r, to_r;
  logic                 so_r;

  logic signed [ACC_BITS-1:0]  opa, opb;
  logic signed [WORD_BITS:0]   alu_sum;
  logic [WORD_BITS:0]          alu_sat;
  logic                        mul_start, mul_done, mul_clip;
  logic [WORD_BITS-1:0]        mul_res;
  logic                        wr_en;
  src_t                        wr_dst;
  logic [WORD_BITS-1:0]        wr_val;

  function automatic logic signed [ACC_BITS-1:0] src_val(input src_t s);
    logic [ACC_BITS-1:0] v;
    case (s)
      SRC_T0:    v = ACC_BITS'($signed(t_r[0]));
      SRC_T1:    v = ACC_BITS'($signed(t_r[1]));
      SRC_T2:    v = ACC_BITS'($signed(t_r[2]));
      SRC_S0:    v = ACC_BITS'($signed(s_r[0]));
      SRC_S1:    v = ACC_BITS'($signed(s_r[1]));
      SRC_S2:    v = ACC_BITS'($signed(s_r[2]));
      SRC_K0:    v = ACC_BITS'($signed(k_r[0]));
      SRC_K1:    v = ACC_BITS'($signed(k_r[1]));
      SRC_K2:    v = ACC_BITS'($signed(k_r[2]));
      SRC_A0:    v = acc_r[0];
      SRC_A1:    v = acc_r[1];
      SRC_A2:    v = acc_r[2];
      SRC_U:     v = ACC_BITS'($signed(u_r));
      SRC_M:     v = ACC_BITS'($signed(m_r));
      SRC_N:     v = ACC_BITS'($signed(n_r));
      SRC_SIGMA: v = ACC_BITS'($signed(sigma_r));
      SRC_BETA:  v = ACC_BITS'($signed(beta_r));
      SRC_RHO:   v = ACC_BITS'($signed(rho_r));
      SRC_H:     v = ACC_BITS'(h_r);
      default:   v = '0;
    endcase
    return $signed(v);
  endfunction

  assign opa = src_val(cmd.uop.a);
  assign opb = src_val(cmd.uop.b);

  always_comb begin
    if (cmd.uop.kind == UK_ADD) begin
      alu_sum = $signed(opa[WORD_BITS:0]) + $signed(opb[WORD_BITS:0]);
    end else begin
      alu_sum = $signed(opa[WORD_BITS:0]) - $signed(opb[WORD_BITS:0]);
    end
    alu_sat = sat_word(alu_sum);
  end

  assign mul_start = cmd.exec && (cmd.uop.kind == UK_MUL);

  lrk_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa),
    .b     (opb[WORD_BITS-1:0]),
    .rnd   (cmd.uop.rnd),
    .done  (mul_done),
    .res   (mul_res),
    .clip  (mul_clip)
  );

  always_comb begin
    wr_en  = 1'b0;
    wr_dst = cmd.uop.dst;
    wr_val = alu_sat[WORD_BITS-1:0];
    if (mul_done) begin
      wr_en  = 1'b1;
      wr_dst = mdst_r;
      wr_val = mul_res;
    end else if (cmd.exec && (cmd.uop.kind == UK_SUB || cmd.uop.kind == UK_ADD)) begin
      wr_en = 1'b1;
    end
  end

  // configuration, time and the sticky clip flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RST;
      beta_r  <= BETA_RST;
      rho_r   <= RHO_RST;
      h_r     <= STEP_RST;
      time_r  <= '0;
      clip_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SIGMA: sigma_r <= cfg_data;
          CFG_BETA:  beta_r  <= cfg_data;
          CFG_RHO:   rho_r   <= cfg_data;
          CFG_STEP:  h_r     <= cfg_data[STEP_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        time_r <= '0;
      end else if (cmd.time_adv) begin
        time_r <= time_r + WORD_BITS'(h_r);
      end
      if (cmd.load || cmd.begin_step) begin
        clip_r <= 1'b0;
      end else if ((mul_done && mul_clip) || (wr_en && !mul_done && alu_sat[WORD_BITS])) begin
        clip_r <= 1'b1;
      end
    end
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r[0] <= '0;
      s_r[1] <= '0;
      s_r[2] <= '0;
    end else begin
      if (cmd.load) begin
        s_r[0] <= load_x;
        s_r[1] <= load_y;
        s_r[2] <= load_z;
      end else if (wr_en && wr_dst == SRC_S0) begin
        s_r[0] <= wr_val;
      end else if (wr_en && wr_dst == SRC_S1) begin
        s_r[1] <= wr_val;
      end else if (wr_en && wr_dst == SRC_S2) begin
        s_r[2] <= wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_step) begin
      t_r[0] <= s_r[0];
      t_r[1] <= s_r[1];
      t_r[2] <= s_r[2];
    end
    if (mul_start) mdst_r <= cmd.uop.dst;
    if (wr_en) begin
      case (wr_dst)
        SRC_T0: t_r[0] <= wr_val;
        SRC_T1: t_r[1] <= wr_val;
        SRC_T2: t_r[2] <= wr_val;
        SRC_K0: k_r[0] <= wr_val;
        SRC_K1: k_r[1] <= wr_val;
        SRC_K2: k_r[2] <= wr_val;
        SRC_U:  u_r    <= wr_val;
        SRC_M:  m_r    <= wr_val;
        SRC_N:  n_r    <= wr_val;
        default: ;
      endcase
    end
    if (cmd.exec) begin
      for (int i = 0; i < 3; i++) begin
        case (cmd.uop.kind)
          UK_ACC_SET:  acc_r[i] <= ACC_BITS'($signed(k_r[i]));
          UK_ACC_ADD1: acc_r[i] <= acc_r[i] + ACC_BITS'($signed(k_r[i]));
          UK_ACC_ADD2: acc_r[i] <= acc_r[i] + (ACC_BITS'($signed(k_r[i])) << 1);
          default: ;
        endcase
      end
    end
    if (cmd.out_load) begin
      xo_r <= s_r[0];
      yo_r <= s_r[1];
      zo_r <= s_r[2];
      to_r <= time_r;
      so_r <= clip_r;
    end
  end

  assign stat.mul_done = mul_done;
  assign x_out     = xo_r;
  assign y_out     = yo_r;
  assign z_out     = zo_r;
  assign time_out  = to_r;
  assign saturated = so_r;

endmodule

// ----- rtl/lrk_ctrl.sv -----
// Controller: input and output handshakes and the micro-step sequencer that
// walks the RK4 table in lrk_pkg. Drives lrk_datapath through cmd_t.
`timescale 1ns / 1ps

module lrk_ctrl import lrk_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  in_kind,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_WAITM  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc, advance;
  uop_t       uop;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign uop      = uop_at(phase_r, idx_r);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    advance       = 1'b0;
    cmd           = '0;
    cmd.uop       = uop;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_t'(in_kind) == KIND_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            cmd.begin_step = 1'b1;
            phase_nxt      = '0;
            idx_nxt        = '0;
            state_nxt      = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.exec = 1'b1;
        if (uop.kind == UK_MUL) begin
          state_nxt = ST_WAITM;
        end else begin
          advance = 1'b1;
        end
      end
      ST_WAITM: begin
        if (stat.mul_done) advance = 1'b1;
      end
      ST_FINISH: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (advance) begin
      if (idx_r == UOP_LAST) begin
        idx_nxt = '0;
        if (phase_r == PHASE_LAST) begin
          cmd.time_adv = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          phase_nxt = phase_r + 1'b1;
          state_nxt = ST_ISSUE;
        end
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_ISSUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mul_done |-> state_r == ST_WAITM)
    else $error("multiplier finished outside a wait");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= UOP_LAST)
    else $error("micro-step index past end of table");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted transaction left controller idle");
`endif

endmodule

// ----- tb/lorenz_rk4_integrator_test.sv -----
// Self-checking testbench for lorenz_rk4_integrator: fixed-point RK4 Lorenz model,
// clocked driver and monitor with random idling. Depends on lrk_pkg and the RTL.
`timescale 1ns / 1ps

module lorenz_rk4_integrator_test;
  import lrk_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [31:0] lx, ly, lz;
  } lorenz_item_t;

  typedef struct {
    logic [31:0] x, y, z, t;
    logic        sat;
  } lorenz_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [31:0] in_load_x = '0, in_load_y = '0, in_load_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_x_out, out_y_out, out_z_out, out_time_out;
  logic        out_saturated;

  lorenz_rk4_integrator u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lorenz_item_t  send_q[$];
  lorenz_state_t traj_q[$];
  int            errors = 0;
  bit            no_gaps = 0;
  int            in_gap = 0, out_gap = 0;

  // model state and coefficients
  longint m_sigma, m_beta, m_rho, m_h, m_x, m_y, m_z;
  logic [31:0] m_time;
  bit          clip_seen;

  function automatic longint clip_w(input longint v);
    if (v > 64'sd2147483647) begin
      clip_seen = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_seen = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // round(a*b / (div * 2^shift)) with ties away from zero, then saturate
  function automatic longint mul_round(input longint a, input longint b,
                                       input int shift, input int div);
    logic signed [127:0] aw, bw;
    logic [127:0] am, bm, p, lim;
    bit neg;
    aw = a;
    bw = b;
    neg = (a < 0) != (b < 0);
    am = (aw < 0) ? -aw : aw;
    bm = (bw < 0) ? -bw : bw;
    p = am * bm + (128'(div) << (shift - 1));
    p = (p >> shift) / div;
    lim = neg ? 128'd2147483648 : 128'd2147483647;
    if (p > lim) begin
      clip_seen = 1;
      p = lim;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic void lorenz_rate(input longint x, y, z, output longint dx, dy, dz);
    dx = mul_round(m_sigma, clip_w(y - x), FRAC_BITS, 1);
    dy = clip_w(mul_round(x, clip_w(m_rho - z), FRAC_BITS, 1) - y);
    dz = clip_w(mul_round(x, y, FRAC_BITS, 1) - mul_round(m_beta, z, FRAC_BITS, 1));
  endfunction

  function automatic lorenz_state_t rk4_advance(input lorenz_item_t it);
    longint a1, b1, c1, a2, b2, c2, a3, b3, c3, a4, b4, c4, tx, ty, tz;
    lorenz_state_t r;
    clip_seen = 0;
    if (it.kind == KIND_LOAD) begin
      m_x = longint'($signed(it.lx));
      m_y = longint'($signed(it.ly));
      m_z = longint'($signed(it.lz));
      m_time = '0;
    end else begin
      lorenz_rate(m_x, m_y, m_z, a1, b1, c1);
      tx = clip_w(m_x + mul_round(a1, m_h, FRAC_BITS + 1, 1));
      ty = clip_w(m_y + mul_round(b1, m_h, FRAC_BITS + 1, 1));
      tz = clip_w(m_z + mul_round(c1, m_h, FRAC_BITS + 1, 1));
      lorenz_rate(tx, ty, tz, a2, b2, c2);
      tx = clip_w(m_x + mul_round(a2, m_h, FRAC_BITS + 1, 1));
      ty = clip_w(m_y + mul_round(b2, m_h, FRAC_BITS + 1, 1));
      tz = clip_w(m_z + mul_round(c2, m_h, FRAC_BITS + 1, 1));
      lorenz_rate(tx, ty, tz, a3, b3, c3);
      tx = clip_w(m_x + mul_round(a3, m_h, FRAC_BITS, 1));
      ty = clip_w(m_y + mul_round(b3, m_h, FRAC_BITS, 1));
      tz = clip_w(m_z + mul_round(c3, m_h, FRAC_BITS, 1));
      lorenz_rate(tx, ty, tz, a4, b4, c4);
      m_x = clip_w(m_x + mul_round(a1 + 2 * a2 + 2 * a3 + a4, m_h, FRAC_BITS, 6));
      m_y = clip_w(m_y + mul_round(b1 + 2 * b2 + 2 * b3 + b4, m_h, FRAC_BITS, 6));
      m_z = clip_w(m_z + mul_round(c1 + 2 * c2 + 2 * c3 + c4, m_h, FRAC_BITS, 6));
      m_time = m_time + 32'(m_h);
    end
    r.x = m_x[31:0];
    r.y = m_y[31:0];
    r.z = m_z[31:0];
    r.t = m_time;
    r.sat = clip_seen;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: hold a stalled transaction, advance on acceptance
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_stall)) begin
      if (in_valid) begin
        traj_q.push_back(rk4_advance(send_q.pop_front()));
        in_gap = pick_gap();
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (send_q.size() > 0) begin
        in_valid  <= 1'b1;
        in_kind   <= send_q[0].kind;
        in_load_x <= send_q[0].lx;
        in_load_y <= send_q[0].ly;
        in_load_z <= send_q[0].lz;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lorenz_state_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (traj_q.size() == 0) begin
          $error("result transaction with nothing outstanding");
          errors++;
        end else begin
          e = traj_q.pop_front();
          if (out_x_out !== e.x) begin
            $error("x_out expected %h actual %h", e.x, out_x_out); errors++;
          end
          if (out_y_out !== e.y) begin
            $error("y_out expected %h actual %h", e.y, out_y_out); errors++;
          end
          if (out_z_out !== e.z) begin
            $error("z_out expected %h actual %h", e.z, out_z_out); errors++;
          end
          if (out_time_out !== e.t) begin
            $error("time_out expected %h actual %h", e.t, out_time_out); errors++;
          end
          if (out_saturated !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, out_saturated); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SIGMA: m_sigma = longint'($signed(val));
      CFG_BETA:  m_beta  = longint'($signed(val));
      CFG_RHO:   m_rho   = longint'($signed(val));
      CFG_STEP:  m_h     = longint'(val[30:0]);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (send_q.size() == 0 && traj_q.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
  endtask

  task automatic push(input kind_t k, input logic [31:0] x, y, z);
    lorenz_item_t it;
    it.kind = k;
    it.lx = x;
    it.ly = y;
    it.lz = z;
    send_q.push_back(it);
  endtask

  function automatic logic [31:0] near_attractor();
    return 32'($signed($urandom_range(0, 6553600)) - 3276800);
  endfunction

  task automatic random_phase(input int n);
    int cnt;
    int steps;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 99) < 80) begin
        push(KIND_LOAD, near_attractor(), near_attractor(), near_attractor());
        steps = $urandom_range(1, 8);
      end else begin
        push(KIND_LOAD, $urandom, $urandom, $urandom);
        steps = $urandom_range(0, 2);
      end
      repeat (steps) push(KIND_STEP, $urandom, $urandom, $urandom);
      cnt += steps + 1;
    end
    drain();
  endtask

  initial begin
    m_sigma = 655360; m_beta = 174763; m_rho = 1835008; m_h = 655;
    m_x = 0; m_y = 0; m_z = 0; m_time = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // a step straight from reset, then the field extremes
    push(KIND_STEP, '0, '0, '0);
    push(KIND_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push(KIND_STEP, '0, '0, '0);
    push(KIND_LOAD, 32'h80000000, 32'h7fffffff, 32'h80000000);
    push(KIND_STEP, '1, '1, '1);
    push(KIND_LOAD, 32'h00010000, 32'h00010000, 32'h00010000);
    repeat (4) push(KIND_STEP, '0, '0, '0);
    push(KIND_LOAD, '0, '0, '0);
    push(KIND_STEP, '0, '0, '0);
    drain();

    write_reg(CFG_SIGMA, 32'd655360);
    write_reg(CFG_BETA, 32'd174763);
    write_reg(CFG_RHO, 32'd1835008);
    write_reg(CFG_STEP, 32'd655);
    no_gaps = 1;
    random_phase(60);
    no_gaps = 0;
    random_phase(80);

    // extreme coefficients and the largest step: saturation and time wrap
    write_reg(CFG_SIGMA, 32'h7fffffff);
    write_reg(CFG_BETA, 32'h80000000);
    write_reg(CFG_RHO, 32'h7fffffff);
    write_reg(CFG_STEP, 32'h7fffffff);
    push(KIND_LOAD, 32'h00010000, 32'h00020000, 32'h00030000);
    repeat (3) push(KIND_STEP, '0, '0, '0);
    random_phase(40);

    write_reg(CFG_SIGMA, 32'h80000000);
    write_reg(CFG_BETA, 32'h7fffffff);
    write_reg(CFG_RHO, 32'h80000000);
    write_reg(CFG_STEP, 32'h0);
    random_phase(40);

    write_reg(CFG_SIGMA, $urandom);
    write_reg(CFG_BETA, $urandom);
    write_reg(CFG_RHO, $urandom);
    write_reg(CFG_STEP, $urandom);
    random_phase(60);

    write_reg(CFG_SIGMA, 32'd655360);
    write_reg(CFG_BETA, 32'd174763);
    write_reg(CFG_RHO, 32'd1835008);
    write_reg(CFG_STEP, 32'($urandom_range(1, 8000)));
    random_phase(120);

    repeat (300) @(posedge clk);
    if (errors == 0 && traj_q.size() == 0) begin
      $display("lorenz_rk4_integrator_test passed");
    end else begin
      $display("lorenz_rk4_integrator_test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("lorenz_rk4_integrator_test failed");
    $finish;
  end

endmodule
